// ===== hw/rtl/clr_pkg.sv =====
package clr_pkg;

    localparam int COORD_BITS = 16;
    localparam int INDEX_BITS = 24;

    // Widths fixed by the register map
    localparam int CLIP_POS_BITS  = 16;
    localparam int CLIP_SIZE_BITS = 15;
    localparam int SURF_BITS      = 15;
    localparam int COLOR_BITS     = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_IDX_BITS   = 3;

    // Endpoint differences and Bresenham error term
    localparam int DELTA_W = COORD_BITS + 1;
    localparam int ERR_W   = COORD_BITS + 3;

    // Clip compare width: room for position plus size without overflow
    localparam int CMP_W = ((COORD_BITS > CLIP_POS_BITS) ? COORD_BITS : CLIP_POS_BITS) + 2;

    // Index arithmetic width: full signed product, at least the address width
    localparam int MUL_W  = COORD_BITS + SURF_BITS + 1;
    localparam int WIDE_W = (MUL_W > INDEX_BITS) ? MUL_W : INDEX_BITS;

    localparam int SURF_RESET = 640;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [INDEX_BITS-1:0]        index_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CLIP_ENABLE   = 3'd0,
        REG_CLIP_LEFT     = 3'd1,
        REG_CLIP_TOP      = 3'd2,
        REG_CLIP_WIDTH    = 3'd3,
        REG_CLIP_HEIGHT   = 3'd4,
        REG_SURFACE_WIDTH = 3'd5,
        REG_DRAW_COLOR    = 3'd6
    } reg_idx_t;

    typedef enum logic {
        ACT_BEGIN   = 1'b0,
        ACT_ADVANCE = 1'b1
    } action_t;

    typedef struct packed {
        logic                              clip_enable;
        logic signed [CLIP_POS_BITS-1:0]   clip_left;
        logic signed [CLIP_POS_BITS-1:0]   clip_top;
        logic        [CLIP_SIZE_BITS-1:0]  clip_width;
        logic        [CLIP_SIZE_BITS-1:0]  clip_height;
        logic        [SURF_BITS-1:0]       surface_width;
        logic        [COLOR_BITS-1:0]      draw_color;
    } cfg_t;

    // Walker result handed to the emit stage
    typedef struct packed {
        logic   valid;
        logic   last;
        coord_t x;
        coord_t y;
    } pix_t;

endpackage

// ===== hw/rtl/clr_cfg.sv =====
module clr_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [clr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [clr_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output clr_pkg::cfg_t                     cfg
);
    import clr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CLIP_ENABLE:   cfg_next.clip_enable   = cfg_data[0];
                REG_CLIP_LEFT:     cfg_next.clip_left     = cfg_data[CLIP_POS_BITS-1:0];
                REG_CLIP_TOP:      cfg_next.clip_top      = cfg_data[CLIP_POS_BITS-1:0];
                REG_CLIP_WIDTH:    cfg_next.clip_width    = cfg_data[CLIP_SIZE_BITS-1:0];
                REG_CLIP_HEIGHT:   cfg_next.clip_height   = cfg_data[CLIP_SIZE_BITS-1:0];
                REG_SURFACE_WIDTH: cfg_next.surface_width = cfg_data[SURF_BITS-1:0];
                REG_DRAW_COLOR:    cfg_next.draw_color    = cfg_data[COLOR_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{clip_enable: 1'b0, clip_left: '0, clip_top: '0, clip_width: '0,
                         clip_height: '0, surface_width: SURF_BITS'(SURF_RESET),
                         draw_color: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/clr_walker.sv =====
module clr_walker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                advance_out,
    input  logic                action,
    input  clr_pkg::coord_t     start_x,
    input  clr_pkg::coord_t     start_y,
    input  clr_pkg::coord_t     end_x,
    input  clr_pkg::coord_t     end_y,
    output logic                pix_valid,
    output clr_pkg::pix_t       pix
);
    import clr_pkg::*;

    coord_t                     cur_x_reg, cur_x_next;
    coord_t                     cur_y_reg, cur_y_next;
    coord_t                     stop_x_reg, stop_x_next;
    coord_t                     stop_y_reg, stop_y_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic [DELTA_W-1:0]         adx_reg, adx_next;
    logic [DELTA_W-1:0]         ady_reg, ady_next;
    logic                       back_reg, back_next;
    logic                       xmaj_reg, xmaj_next;
    logic                       walking_reg, walking_next;
    logic                       stage_reg, stage_next;
    pix_t                       pix_reg, pix_next;

    // Begin path
    logic signed [DELTA_W-1:0]  dy_raw;
    logic signed [DELTA_W-1:0]  dx;
    logic                       swap;
    coord_t                     x1, y1, x2, y2;
    logic [DELTA_W-1:0]         adx_b, ady_b;
    logic                       back_b, xmaj_b;

    // Advance path
    logic [DELTA_W-1:0]         inc, lim;
    logic signed [ERR_W:0]      e1, e2;
    logic signed [ERR_W+1:0]    twice, lim_ext;
    logic                       take;
    coord_t                     x_step, nx, ny;

    always_comb
    begin
        dy_raw = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
        swap   = dy_raw[DELTA_W-1] || (dy_raw == '0);
        x1     = swap ? end_x   : start_x;
        y1     = swap ? end_y   : start_y;
        x2     = swap ? start_x : end_x;
        y2     = swap ? start_y : end_y;
        dx     = $signed({x2[COORD_BITS-1], x2}) - $signed({x1[COORD_BITS-1], x1});
        back_b = dx[DELTA_W-1];
        adx_b  = back_b ? $unsigned(-dx) : $unsigned(dx);
        ady_b  = swap ? $unsigned(-dy_raw) : $unsigned(dy_raw);
        xmaj_b = adx_b > ady_b;
    end

    always_comb
    begin
        // Bresenham step: the major axis always moves, the minor one on overflow
        inc     = xmaj_reg ? ady_reg : adx_reg;
        lim     = xmaj_reg ? adx_reg : ady_reg;
        e1      = $signed({err_reg[ERR_W-1], err_reg})
                + $signed({{(ERR_W + 1 - DELTA_W){1'b0}}, inc});
        twice   = $signed({e1, 1'b0});
        lim_ext = $signed({{(ERR_W + 2 - DELTA_W){1'b0}}, lim});
        take    = twice > lim_ext;
        e2      = take ? (e1 - $signed({{(ERR_W + 1 - DELTA_W){1'b0}}, lim})) : e1;
        x_step  = back_reg ? coord_t'({COORD_BITS{1'b1}}) : coord_t'(1);
        nx      = (xmaj_reg || take) ? coord_t'(cur_x_reg + x_step) : cur_x_reg;
        ny      = (!xmaj_reg || take) ? coord_t'(cur_y_reg + coord_t'(1)) : cur_y_reg;
    end

    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        stop_x_next  = stop_x_reg;
        stop_y_next  = stop_y_reg;
        err_next     = err_reg;
        adx_next     = adx_reg;
        ady_next     = ady_reg;
        back_next    = back_reg;
        xmaj_next    = xmaj_reg;
        walking_next = walking_reg;
        pix_next     = pix_reg;
        stage_next   = advance_out ? 1'b0 : stage_reg;

        if (accept)
        begin
            stage_next = 1'b1;
            pix_next   = '0;
            if (action_t'(action) == ACT_BEGIN)
            begin
                cur_x_next     = x1;
                cur_y_next     = y1;
                stop_x_next    = x2;
                stop_y_next    = y2;
                err_next       = '0;
                adx_next       = adx_b;
                ady_next       = ady_b;
                back_next      = back_b;
                xmaj_next      = xmaj_b;
                pix_next.valid = 1'b1;
                pix_next.x     = x1;
                pix_next.y     = y1;
                pix_next.last  = xmaj_b ? (x1 == x2) : (y1 == y2);
                walking_next   = !pix_next.last;
            end
            else if (walking_reg)
            begin
                cur_x_next     = nx;
                cur_y_next     = ny;
                err_next       = e2[ERR_W-1:0];
                pix_next.valid = 1'b1;
                pix_next.x     = nx;
                pix_next.y     = ny;
                pix_next.last  = xmaj_reg ? (nx == stop_x_reg) : (ny == stop_y_reg);
                walking_next   = !pix_next.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            stop_x_reg  <= '0;
            stop_y_reg  <= '0;
            err_reg     <= '0;
            adx_reg     <= '0;
            ady_reg     <= '0;
            back_reg    <= 1'b0;
            xmaj_reg    <= 1'b0;
            walking_reg <= 1'b0;
            stage_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            stop_x_reg  <= stop_x_next;
            stop_y_reg  <= stop_y_next;
            err_reg     <= err_next;
            adx_reg     <= adx_next;
            ady_reg     <= ady_next;
            back_reg    <= back_next;
            xmaj_reg    <= xmaj_next;
            walking_reg <= walking_next;
            stage_reg   <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    assign pix_valid = stage_reg;
    assign pix       = pix_reg;

endmodule

// ===== hw/rtl/clr_emit.sv =====
module clr_emit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           stage_valid,
    input  clr_pkg::pix_t                  pix,
    input  clr_pkg::cfg_t                  cfg,
    output logic                           out_valid,
    output logic                           pixel_valid,
    output clr_pkg::coord_t                pixel_x,
    output clr_pkg::coord_t                pixel_y,
    output clr_pkg::index_t                pixel_index,
    output logic                           inside_clip,
    output logic [clr_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                           last_pixel
);
    import clr_pkg::*;

    logic                    out_valid_reg, out_valid_next;
    logic                    valid_reg;
    coord_t                  x_reg, y_reg;
    index_t                  index_reg, index_next;
    logic                    inside_reg, inside_next;
    logic [COLOR_BITS-1:0]   color_reg;
    logic                    last_reg;

    coord_t                  px, py;
    logic signed [CMP_W-1:0] cx, cy, cl, ct, cr, cb;
    logic signed [WIDE_W-1:0] y_wide, sw_wide, x_wide, prod, sum;

    always_comb
    begin
        px = pix.x;
        py = pix.y;
        cx = CMP_W'(px);
        cy = CMP_W'(py);
        cl = CMP_W'(cfg.clip_left);
        ct = CMP_W'(cfg.clip_top);
        cr = cl + $signed({{(CMP_W - CLIP_SIZE_BITS){1'b0}}, cfg.clip_width});
        cb = ct + $signed({{(CMP_W - CLIP_SIZE_BITS){1'b0}}, cfg.clip_height});
        inside_next = !cfg.clip_enable || ((cx >= cl) && (cx < cr) && (cy >= ct) && (cy < cb));

        // Row start plus column, wrapped to the address width
        y_wide     = WIDE_W'(py);
        x_wide     = WIDE_W'(px);
        sw_wide    = $signed({{(WIDE_W - SURF_BITS){1'b0}}, cfg.surface_width});
        prod       = y_wide * sw_wide;
        sum        = prod + x_wide;
        index_next = sum[INDEX_BITS-1:0];

        out_valid_next = load ? stage_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            // An advance with no segment gives an all-zero result
            valid_reg  <= pix.valid;
            x_reg      <= pix.valid ? pix.x : '0;
            y_reg      <= pix.valid ? pix.y : '0;
            index_reg  <= pix.valid ? index_next : '0;
            inside_reg <= pix.valid && inside_next;
            color_reg  <= pix.valid ? cfg.draw_color : '0;
            last_reg   <= pix.valid && pix.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_valid = valid_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign pixel_index = index_reg;
    assign inside_clip = inside_reg;
    assign pixel_color = color_reg;
    assign last_pixel  = last_reg;

endmodule

// ===== hw/rtl/clipped_line_rasterizer.sv =====
// Channel   Direction  Handshake              Request
// in        input      in_valid / in_stall    action, start_x, start_y, end_x, end_y
// out       output     out_valid / out_stall  pixel_valid .. last_pixel
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per clock unless the output stalls: the walker step (one add and compare on the error term)
// lands in the stage register, index multiply and clip test in the result register.
// A request passes the stage register, then the result register; sustained rate is one per cycle while unstalled.
// Reset clears the walker and the clip registers; surface width comes up as 640.
// A stalled result holds; one request more is taken into the stage register.
module clipped_line_rasterizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  clr_pkg::coord_t                   start_x,
    input  clr_pkg::coord_t                   start_y,
    input  clr_pkg::coord_t                   end_x,
    input  clr_pkg::coord_t                   end_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              pixel_valid,
    output clr_pkg::coord_t                   pixel_x,
    output clr_pkg::coord_t                   pixel_y,
    output clr_pkg::index_t                   pixel_index,
    output logic                              inside_clip,
    output logic [clr_pkg::COLOR_BITS-1:0]    pixel_color,
    output logic                              last_pixel,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [clr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [clr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import clr_pkg::*;

    cfg_t cfg;
    pix_t pix;
    logic stage_valid;
    logic out_load;
    logic in_accept;

    // Result register frees up when empty or being taken
    assign out_load  = !out_valid || !out_stall;
    assign in_stall  = stage_valid && !out_load;
    assign in_accept = in_valid && !in_stall;

    clr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clr_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .advance_out (out_load),
        .action      (action),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .pix_valid   (stage_valid),
        .pix         (pix)
    );

    clr_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .stage_valid (stage_valid),
        .pix         (pix),
        .cfg         (cfg),
        .out_valid   (out_valid),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_index (pixel_index),
        .inside_clip (inside_clip),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule

// ===== hw/rtl/clr_checker.sv =====
module clr_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              action,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              pixel_valid,
    input  clr_pkg::coord_t                   pixel_x,
    input  clr_pkg::coord_t                   pixel_y,
    input  clr_pkg::index_t                   pixel_index,
    input  logic                              inside_clip,
    input  logic [clr_pkg::COLOR_BITS-1:0]    pixel_color,
    input  logic                              last_pixel
);
    import clr_pkg::*;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_index))
        else $error("stalled result changed");

    // Empty result register never pushes back on the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // A result with no pixel carries nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pixel_valid |-> (pixel_x == '0) && (pixel_y == '0) &&
            (pixel_index == '0) && !inside_clip && (pixel_color == '0) && !last_pixel)
        else $error("empty result not zero");

    // A begin request always produces a pixel once it leaves the stage register unstalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action_t'(action) == ACT_BEGIN) ##1 !out_stall
            |=> out_valid && pixel_valid)
        else $error("begin request lost its first pixel");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (.*);

// ===== sim/testbench.sv =====
module testbench;

    import clr_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RAND_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 153;
    localparam int NO_PRESET       = -1;

    typedef struct packed {
        logic                  valid;
        coord_t                x;
        coord_t                y;
        index_t                addr;
        logic                  in_clip;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_rec_t;

    typedef struct packed {
        int         preset;
        action_t    act;
        int         sx;
        int         sy;
        int         ex;
        int         ey;
        bit         typed;
        pixel_rec_t want;
    } step_row_t;

    localparam pixel_rec_t NO_PIXEL   = '0;
    localparam pixel_rec_t ORIGIN_DOT = '{valid: 1'b1, x: 0, y: 0, addr: 0, in_clip: 1'b1,
                                          color: 0, last: 1'b1};

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     action;
    coord_t                   start_x;
    coord_t                   start_y;
    coord_t                   end_x;
    coord_t                   end_y;
    logic                     out_valid;
    logic                     out_stall;
    logic                     pixel_valid;
    coord_t                   pixel_x;
    coord_t                   pixel_y;
    index_t                   pixel_index;
    logic                     inside_clip;
    logic [COLOR_BITS-1:0]    pixel_color;
    logic                     last_pixel;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // Directed rows: idle advance, single-pixel segment, run past the end, extremes,
    // restart mid-walk, swapped endpoints, register writes between steps of a segment.
    step_row_t directed_rows [24] = '{
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b1, NO_PIXEL},
        '{NO_PRESET, ACT_BEGIN, 0, 0, 0, 0, 1'b1, ORIGIN_DOT},
        '{NO_PRESET, ACT_ADVANCE, 123, -45, 6, 7, 1'b1, NO_PIXEL},
        '{NO_PRESET, ACT_BEGIN, -32768, -32768, 32767, 32767, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, -1, -1, -1, -1, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 32767, 32767, -32768, -32768, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_BEGIN, 1, 3, -2, 3, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b1, NO_PIXEL},
        '{0, ACT_BEGIN, 10, 20, 13, 2, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL},
        '{1, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL},
        '{2, ACT_BEGIN, 32767, -32768, -32768, 32767, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_BEGIN, 32767, 32767, 32767, 32767, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_BEGIN, -7, 0, 3, -4, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_BEGIN, -32768, 32767, -32768, -32768, 1'b0, NO_PIXEL},
        '{NO_PRESET, ACT_ADVANCE, 0, 0, 0, 0, 1'b0, NO_PIXEL}
    };

    // Line walker copy and register shadow
    cfg_t   setting;
    longint pen_x, pen_y, goal_x, goal_y, err_term, run_x, run_y;
    bit     step_left, long_x, drawing;

    pixel_rec_t expected_pixels [$];

    int send_idle_pct = 19;
    int recv_idle_pct = 63;
    int hold_ticket   = 0;
    int mismatches    = 0;
    int n_checked     = 0;
    int n_begin       = 0;
    int n_advance     = 0;
    int n_cfg_writes  = 0;
    int n_settings    = 0;
    int quiet_cycles  = 0;

    clipped_line_rasterizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_index (pixel_index),
        .inside_clip (inside_clip),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the walker by one request and return the pixel it should produce
    function automatic pixel_rec_t walk_step(input action_t act, input coord_t sx,
                                             input coord_t sy, input coord_t ex,
                                             input coord_t ey);
        longint     x1, y1, x2, y2, t, dx, left, top, flat;
        pixel_rec_t pix;
        pix = '0;
        if (act == ACT_BEGIN)
        begin
            x1 = sx;
            y1 = sy;
            x2 = ex;
            y2 = ey;
            // walk never heads towards smaller y
            if (y2 - y1 <= 0)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            dx        = x2 - x1;
            step_left = dx < 0;
            run_x     = step_left ? -dx : dx;
            run_y     = y2 - y1;
            long_x    = run_x > run_y;
            pen_x     = x1;
            pen_y     = y1;
            goal_x    = x2;
            goal_y    = y2;
            err_term  = 0;
            drawing   = 1'b1;
        end
        else
        begin
            if (!drawing)
                return pix;
            if (long_x)
            begin
                pen_x    += step_left ? -1 : 1;
                err_term += run_y;
                if (2 * err_term > run_x)
                begin
                    pen_y    += 1;
                    err_term -= run_x;
                end
            end
            else
            begin
                pen_y    += 1;
                err_term += run_x;
                if (2 * err_term > run_y)
                begin
                    pen_x    += step_left ? -1 : 1;
                    err_term -= run_y;
                end
            end
        end
        left        = longint'($signed(setting.clip_left));
        top         = longint'($signed(setting.clip_top));
        flat        = pen_y * longint'(setting.surface_width) + pen_x;
        pix.valid   = 1'b1;
        pix.x       = coord_t'(pen_x);
        pix.y       = coord_t'(pen_y);
        pix.addr    = index_t'(flat);
        pix.in_clip = !setting.clip_enable ||
                      (pen_x >= left && pen_x < left + longint'(setting.clip_width) &&
                       pen_y >= top && pen_y < top + longint'(setting.clip_height));
        pix.color   = setting.draw_color;
        pix.last    = long_x ? (pen_x == goal_x) : (pen_y == goal_y);
        if (pix.last)
            drawing = 1'b0;
        return pix;
    endfunction

    function automatic cfg_t preset_setting(input int n);
        cfg_t c;
        case (n)
            0: c = '{clip_enable: 1'b1, clip_left: -3, clip_top: 2, clip_width: 6,
                     clip_height: 5, surface_width: 0, draw_color: 32'h5A3C_96E1};
            // empty clip window, widest surface
            1: c = '{clip_enable: 1'b1, clip_left: -32768, clip_top: 32767, clip_width: 0,
                     clip_height: 32767, surface_width: 32767, draw_color: 32'hFFFF_FFFF};
            2: c = '{clip_enable: 1'b1, clip_left: -32768, clip_top: -32768,
                     clip_width: 32767, clip_height: 32767, surface_width: 1, draw_color: 0};
            default: c = '{clip_enable: 1'b1, clip_left: 32767, clip_top: -32768,
                           clip_width: 32767, clip_height: 32767, surface_width: 16384,
                           draw_color: 32'hFFFF_FFFF};
        endcase
        return c;
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c.clip_enable = ($urandom_range(0, 3) != 0);
        c.clip_left   = ($urandom_range(0, 9) == 0) ? CLIP_POS_BITS'($urandom())
                        : CLIP_POS_BITS'(int'($urandom_range(0, 80)) - 50);
        c.clip_top    = ($urandom_range(0, 9) == 0) ? CLIP_POS_BITS'($urandom())
                        : CLIP_POS_BITS'(int'($urandom_range(0, 80)) - 50);
        case ($urandom_range(0, 9))
            0:       c.clip_width = 0;
            1:       c.clip_width = 32767;
            default: c.clip_width = $urandom_range(1, 70);
        endcase
        case ($urandom_range(0, 9))
            0:       c.clip_height = 0;
            1:       c.clip_height = 32767;
            default: c.clip_height = $urandom_range(1, 70);
        endcase
        case ($urandom_range(0, 5))
            0:       c.surface_width = 0;
            1:       c.surface_width = 1;
            2:       c.surface_width = 640;
            3:       c.surface_width = 16384;
            4:       c.surface_width = 32767;
            default: c.surface_width = $urandom_range(0, 32767);
        endcase
        c.draw_color = $urandom();
        return c;
    endfunction

    function automatic coord_t clamp_coord(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return coord_t'(v);
    endfunction

    function automatic int pick_centre();
        case ($urandom_range(0, 9))
            0:       return 32740;
            1:       return -32745;
            default: return int'($urandom_range(0, 100)) - 60;
        endcase
    endfunction

    function automatic coord_t extreme_coord();
        case ($urandom_range(0, 6))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            default: return 32767;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("pixel %0d: %s expected %h, got %h", n_checked, name, want, got);
        end
    endfunction

    task automatic send_request(input action_t act, input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey, input bit typed,
                                input pixel_rec_t typed_pix);
        pixel_rec_t pix;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pix = walk_step(act, sx, sy, ex, ey);
        expected_pixels.push_back(typed ? typed_pix : pix);
        if (act == ACT_BEGIN)
            n_begin++;
        else
            n_advance++;
    endtask

    // Hold the input side until every outstanding pixel has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input cfg_t c);
        reg_idx_t                 r;
        logic [CFG_DATA_BITS-1:0] word;
        r = r.first();
        do
        begin
            // junk in the unused upper bits must be dropped
            word = $urandom();
            case (r)
                REG_CLIP_ENABLE:   word[0]                  = c.clip_enable;
                REG_CLIP_LEFT:     word[CLIP_POS_BITS-1:0]  = c.clip_left;
                REG_CLIP_TOP:      word[CLIP_POS_BITS-1:0]  = c.clip_top;
                REG_CLIP_WIDTH:    word[CLIP_SIZE_BITS-1:0] = c.clip_width;
                REG_CLIP_HEIGHT:   word[CLIP_SIZE_BITS-1:0] = c.clip_height;
                REG_SURFACE_WIDTH: word[SURF_BITS-1:0]      = c.surface_width;
                default:           word                     = c.draw_color;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= r;
            cfg_data  <= word;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            n_cfg_writes++;
            r = r.next();
        end
        while (r != r.first());
        cfg_valid <= 1'b0;
        setting = c;
        n_settings++;
    endtask

    // Result side: check each accepted pixel, then pick the stall for the next cycle
    initial
    begin
        int         hold_seen;
        int         hold_left;
        pixel_rec_t want;
        hold_seen = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel %0d: result with nothing outstanding", n_checked);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_valid", want.valid, pixel_valid);
                    check_field("pixel_x", want.x, pixel_x);
                    check_field("pixel_y", want.y, pixel_y);
                    check_field("pixel_index", want.addr, pixel_index);
                    check_field("inside_clip", want.in_clip, inside_clip);
                    check_field("pixel_color", want.color, pixel_color);
                    check_field("last_pixel", want.last, last_pixel);
                end
                n_checked++;
            end
            if (hold_ticket != hold_seen)
            begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles, %0d pixels outstanding",
                         quiet_cycles, expected_pixels.size());
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int        ph, mode, count, sel, cx, cy, n_adv, len, dxa, dya, k;
        bit        held;
        coord_t    ax, ay, bx, by;
        step_row_t row;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        action    <= ACT_BEGIN;
        start_x   <= '0;
        start_y   <= '0;
        end_x     <= '0;
        end_y     <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_CLIP_ENABLE;
        cfg_data  <= '0;

        setting = '{clip_enable: 1'b0, clip_left: 0, clip_top: 0, clip_width: 0,
                    clip_height: 0, surface_width: SURF_RESET, draw_color: 0};
        pen_x = 0; pen_y = 0; goal_x = 0; goal_y = 0;
        err_term = 0; run_x = 0; run_y = 0;
        step_left = 1'b0; long_x = 1'b0; drawing = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 24; k++)
        begin
            row = directed_rows[k];
            if (row.preset != NO_PRESET)
            begin
                drain();
                configure(preset_setting(row.preset));
            end
            send_request(row.act, coord_t'(row.sx), coord_t'(row.sy), coord_t'(row.ex),
                         coord_t'(row.ey), row.typed, row.want);
        end

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            mode          = ph / 3;
            send_idle_pct = (mode == 0) ? 19 : ((mode == 1) ? 63 : 0);
            recv_idle_pct <= (mode == 0) ? 63 : ((mode == 1) ? 19 : 0);
            configure((ph == 4) ? preset_setting(3) : random_setting());
            count = 0;
            held  = 1'b0;
            while (count < ITEMS_PER_PHASE)
            begin
                // long output hold-off while the input keeps pushing
                if (!held && count >= 30 && (ph == 0 || ph == 7))
                begin
                    hold_ticket <= hold_ticket + 1;
                    held = 1'b1;
                end
                sel = $urandom_range(0, 99);
                if (sel < 6)
                begin
                    send_request(ACT_ADVANCE, coord_t'($urandom()), coord_t'($urandom()),
                                 coord_t'($urandom()), coord_t'($urandom()), 1'b0, NO_PIXEL);
                    count++;
                end
                else if (sel < 8)
                    drain();
                else
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 70)
                    begin
                        cx = pick_centre();
                        cy = pick_centre();
                        ax = clamp_coord(cx + int'($urandom_range(0, 48)) - 24);
                        ay = clamp_coord(cy + int'($urandom_range(0, 48)) - 24);
                        bx = clamp_coord(cx + int'($urandom_range(0, 48)) - 24);
                        by = clamp_coord(cy + int'($urandom_range(0, 48)) - 24);
                    end
                    else if (sel < 85)
                    begin
                        ax = coord_t'($urandom());
                        ay = coord_t'($urandom());
                        bx = coord_t'($urandom());
                        by = coord_t'($urandom());
                    end
                    else
                    begin
                        ax = extreme_coord();
                        ay = extreme_coord();
                        bx = extreme_coord();
                        by = extreme_coord();
                    end
                    dxa = int'(bx) - int'(ax);
                    dya = int'(by) - int'(ay);
                    dxa = (dxa < 0) ? -dxa : dxa;
                    dya = (dya < 0) ? -dya : dya;
                    len = (dxa > dya) ? dxa : dya;
                    // walk short segments mostly to the end or a little past; cut long ones short
                    if (len <= 64)
                        n_adv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len)
                                                            : len + $urandom_range(0, 1);
                    else
                        n_adv = $urandom_range(0, 8);
                    send_request(ACT_BEGIN, ax, ay, bx, by, 1'b0, NO_PIXEL);
                    count++;
                    repeat (n_adv)
                    begin
                        send_request(ACT_ADVANCE, coord_t'($urandom()), coord_t'($urandom()),
                                     coord_t'($urandom()), coord_t'($urandom()), 1'b0,
                                     NO_PIXEL);
                        count++;
                    end
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("summary: %0d requests (%0d begins, %0d advances), %0d pixels checked, %0d mismatches",
                 n_begin + n_advance, n_begin, n_advance, n_checked, mismatches);
        $display("summary: %0d register writes over %0d settings, idling swapped then off, %s",
                 n_cfg_writes, n_settings, "two long output hold-offs");
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
